@@ design/brre_pkg.sv @@
// Package for the binary row run extractor.
// Holds field widths, register indexes and the result record type.
// Used by every module of the block; depends on nothing.
package brre_pkg;

  localparam int PIX_W    = 8;
  localparam int SEG_W    = 10;
  localparam int MINW_W   = 11;
  localparam int SKIP_W   = 10;
  localparam int GAP_W    = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SKIP  = 1'b1;

  localparam logic [MINW_W-1:0] MIN_WIDTH_RESET = 11'd1;
  localparam logic [SKIP_W-1:0] MAX_SKIP_RESET  = 10'd0;

  typedef struct packed {
    logic             has_segment;
    logic [SEG_W-1:0] seg_start;
    logic [SEG_W-1:0] seg_end;
    logic             row_end;
  } result_t;

endpackage

@@ design/brre_cfg.sv @@
// Configuration registers of the run extractor: min_width and max_skip.
// Depends on brre_pkg for widths, reset values and register indexes.
module brre_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [brre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brre_pkg::CFG_W-1:0]     cfg_data,
  output logic [brre_pkg::MINW_W-1:0]    min_width,
  output logic [brre_pkg::SKIP_W-1:0]    max_skip
);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= brre_pkg::MIN_WIDTH_RESET;
      max_skip  <= brre_pkg::MAX_SKIP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        brre_pkg::REG_MIN_WIDTH: min_width <= cfg_data[brre_pkg::MINW_W-1:0];
        brre_pkg::REG_MAX_SKIP:  max_skip  <= cfg_data[brre_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/brre_core.sv @@
// Input register, run state and per-pixel run logic of the extractor.
// Produces at most one result record per item. Depends on brre_pkg.
module brre_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [brre_pkg::PIX_W-1:0]  pixel,
  input  logic                        row_last,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [brre_pkg::MINW_W-1:0] min_width,
  input  logic [brre_pkg::SKIP_W-1:0] max_skip,
  input  logic                        out_free,
  output logic                        res_load,
  output brre_pkg::result_t           res
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int BASE_W = (COL_W > brre_pkg::GAP_W) ? COL_W : brre_pkg::GAP_W;
  localparam int SW = BASE_W + 2;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);

  // Input stage.
  logic s1_valid;
  logic s1_fg;
  logic s1_last;

  // Run state.
  logic                       in_run;
  logic [COL_W-1:0]           run_start;
  logic [brre_pkg::GAP_W-1:0] gap_count;
  logic [COL_W-1:0]           column;

  logic                       adv;
  logic                       in_run_next;
  logic [COL_W-1:0]           run_start_next;
  logic [brre_pkg::GAP_W-1:0] gap_count_next;
  logic                       close_emit;
  logic                       flush_emit;
  logic                       emit;
  logic [SW-1:0]              x_w;
  logic [SW-1:0]              rs_w;
  logic [SW-1:0]              gap_w;
  logic [SW-1:0]              last_fg_w;

  assign adv         = s1_valid && out_free;
  assign pixel_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_ready && pixel_valid) begin
      s1_fg   <= (pixel != '0);
      s1_last <= row_last;
    end
  end

  assign x_w = SW'(column);

  always_comb begin
    in_run_next    = in_run;
    run_start_next = run_start;
    gap_count_next = gap_count;
    close_emit     = 1'b0;
    if (in_run) begin
      if (!s1_fg) begin
        if (gap_count < brre_pkg::GAP_MAX) begin
          gap_count_next = gap_count + 1'b1;
        end
        // The gap has outgrown the bridging limit, so the run closes here.
        if (gap_count_next > brre_pkg::GAP_W'(max_skip)) begin
          close_emit  = (x_w - SW'(run_start)) >= SW'(min_width);
          in_run_next = 1'b0;
        end
      end else begin
        gap_count_next = '0;
      end
    end else if (s1_fg) begin
      run_start_next = column;
      in_run_next    = 1'b1;
      gap_count_next = '0;
    end
  end

  assign rs_w  = SW'(run_start_next);
  assign gap_w = SW'(gap_count_next);
  assign flush_emit = s1_last && in_run_next &&
                      ((x_w + SW'(1) - rs_w) >= SW'(min_width));
  assign emit = close_emit || flush_emit;

  // Last foreground column; falls back to the run start once the column
  // has saturated and the gap reaches past it.
  assign last_fg_w = (x_w >= rs_w + gap_w) ? (x_w - gap_w) : rs_w;

  assign res_load        = adv && (emit || s1_last);
  assign res.has_segment = emit;
  assign res.seg_start   = emit ? rs_w[brre_pkg::SEG_W-1:0] : '0;
  assign res.seg_end     = emit ? last_fg_w[brre_pkg::SEG_W-1:0] : '0;
  assign res.row_end     = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run    <= 1'b0;
      run_start <= '0;
      gap_count <= '0;
      column    <= '0;
    end else if (adv) begin
      if (s1_last) begin
        in_run    <= 1'b0;
        run_start <= '0;
        gap_count <= '0;
        column    <= '0;
      end else begin
        in_run    <= in_run_next;
        run_start <= run_start_next;
        gap_count <= gap_count_next;
        if (column < COL_MAX) begin
          column <= column + 1'b1;
        end
      end
    end
  end

endmodule

@@ design/brre_outreg.sv @@
// Result register of the run extractor, holding one item for the consumer.
// Depends on brre_pkg for the result record type.
module brre_outreg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_load,
  input  brre_pkg::result_t           res,
  output logic                        out_free,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        has_segment,
  output logic [brre_pkg::SEG_W-1:0]  seg_start,
  output logic [brre_pkg::SEG_W-1:0]  seg_end,
  output logic                        row_end
);

  brre_pkg::result_t held;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_load) begin
      held <= res;
    end
  end

  assign has_segment = held.has_segment;
  assign seg_start   = held.seg_start;
  assign seg_end     = held.seg_end;
  assign row_end     = held.row_end;

endmodule

@@ design/binary_row_run_extractor.sv @@
// Binary row run extractor: finds gap-bridged foreground runs in pixel rows.
// A result passes through the input register and then the result register
// before it is offered to the consumer.
// Throughput: one item per cycle; the input register and result register
// both advance whenever the result register is empty or being taken.
// Reset (synchronous, rst high) clears the run state, the column counter and
// both valid flags, and sets min_width to 1 and max_skip to 0.
module binary_row_run_extractor #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [brre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brre_pkg::CFG_W-1:0]     cfg_data,
  input  logic [brre_pkg::PIX_W-1:0]     pixel,
  input  logic                           row_last,
  input  logic                           pixel_valid,
  output logic                           pixel_ready,
  output logic                           has_segment,
  output logic [brre_pkg::SEG_W-1:0]     seg_start,
  output logic [brre_pkg::SEG_W-1:0]     seg_end,
  output logic                           row_end,
  output logic                           result_valid,
  input  logic                           result_ready
);

  logic [brre_pkg::MINW_W-1:0] min_width;
  logic [brre_pkg::SKIP_W-1:0] max_skip;
  logic                        out_free;
  logic                        res_load;
  brre_pkg::result_t           res;

  brre_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .min_width (min_width),
    .max_skip  (max_skip)
  );

  brre_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .row_last    (row_last),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .min_width   (min_width),
    .max_skip    (max_skip),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  brre_outreg u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .has_segment  (has_segment),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .row_end      (row_end)
  );

endmodule

@@ design/brre_checker.sv @@
// Port-level checks for the binary row run extractor, bound to the top level.
// Depends on brre_pkg for field widths.
module brre_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       has_segment,
  input logic [brre_pkg::SEG_W-1:0] seg_start,
  input logic [brre_pkg::SEG_W-1:0] seg_end,
  input logic                       row_end,
  input logic                       result_valid,
  input logic                       result_ready
);

  // A waiting result keeps its contents until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(has_segment) &&
      $stable(seg_start) && $stable(seg_end) && $stable(row_end))
    else $error("result item changed while stalled");

  // Every result item carries a run, a row end, or both.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> has_segment || row_end)
    else $error("empty result item");

  // A row-end item without a run reports zero columns.
  a_zero_cols: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_segment |-> seg_start == '0 && seg_end == '0)
    else $error("columns set on an item without a run");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result offered right after reset");

endmodule

bind binary_row_run_extractor brre_checker u_brre_checker (
  .clk          (clk),
  .rst          (rst),
  .has_segment  (has_segment),
  .seg_start    (seg_start),
  .seg_end      (seg_end),
  .row_end      (row_end),
  .result_valid (result_valid),
  .result_ready (result_ready)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for binary_row_run_extractor.
// Holds the pixel driver, result monitor and a run tracker that predicts each result.
// Depends on brre_pkg and the block's RTL.
module tb_top;

  localparam int COLS         = 1024;
  localparam int STUCK_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_ITEMS  = 25;
  localparam int RANDOM_PHASES = 12;

  typedef struct packed {
    logic [brre_pkg::PIX_W-1:0] value;
    logic                       last;
  } pixel_item_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [brre_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [brre_pkg::CFG_W-1:0]     cfg_data = '0;
  logic [brre_pkg::PIX_W-1:0]     pixel = '0;
  logic                           row_last = 1'b0;
  logic                           pixel_valid = 1'b0;
  logic                           pixel_ready;
  logic                           has_segment;
  logic [brre_pkg::SEG_W-1:0]     seg_start;
  logic [brre_pkg::SEG_W-1:0]     seg_end;
  logic                           row_end;
  logic                           result_valid;
  logic                           result_ready = 1'b0;

  // Run tracker state and its copy of the registers.
  bit run_open = 1'b0;
  int run_begin = 0;
  int gap_cnt = 0;
  int col_cnt = 0;
  int width_floor = 1;
  int skip_limit = 0;

  pixel_item_t       pixel_backlog[$];
  brre_pkg::result_t due_results[$];
  pixel_item_t       staged;
  brre_pkg::result_t staged_result;
  brre_pkg::result_t expected_now;

  int errors = 0;
  int items_queued = 0;
  int result_index = 0;
  int hold_requests = 0;
  int holds_seen = 0;
  int hold_left = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_tick = 0;
  logic [1:0] stall_mode = 2'd0;
  int stuck_cycles = 0;

  binary_row_run_extractor #(.MAX_WIDTH(COLS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .row_last     (row_last),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .has_segment  (has_segment),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .row_end      (row_end),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Last foreground column of the open run when the current column is x.
  function automatic int last_lit(input int x);
    if (x >= run_begin + gap_cnt) begin
      return x - gap_cnt;
    end
    return run_begin;
  endfunction

  // Advances the run tracker by one pixel; returns 1 when the pixel yields a result.
  function automatic bit track_pixel(input logic [brre_pkg::PIX_W-1:0] value,
                                     input logic last,
                                     output brre_pkg::result_t res);
    bit fg;
    bit emit;
    int x;
    int s_start;
    int s_end;
    fg = (value != '0);
    emit = 1'b0;
    x = col_cnt;
    s_start = 0;
    s_end = 0;
    if (run_open) begin
      if (!fg) begin
        if (gap_cnt < int'(brre_pkg::GAP_MAX)) begin
          gap_cnt++;
        end
        if (gap_cnt > skip_limit) begin
          if (x - run_begin >= width_floor) begin
            emit = 1'b1;
            s_start = run_begin;
            s_end = last_lit(x);
          end
          run_open = 1'b0;
        end
      end else begin
        gap_cnt = 0;
      end
    end else if (fg) begin
      run_begin = x;
      run_open = 1'b1;
      gap_cnt = 0;
    end
    if (last) begin
      if (run_open && (x + 1 - run_begin) >= width_floor) begin
        emit = 1'b1;
        s_start = run_begin;
        s_end = last_lit(x);
      end
      run_open = 1'b0;
      run_begin = 0;
      gap_cnt = 0;
      col_cnt = 0;
    end else if (col_cnt < COLS - 1) begin
      col_cnt++;
    end
    res.has_segment = emit;
    res.seg_start = emit ? brre_pkg::SEG_W'(s_start) : '0;
    res.seg_end = emit ? brre_pkg::SEG_W'(s_end) : '0;
    res.row_end = last;
    return emit || last;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 50) begin
      $display("tb_top: mismatch at result %0d: %s", result_index, what);
    end
    errors++;
  endtask

  task automatic write_reg(input logic [brre_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= brre_pkg::CFG_W'(val);
    if (idx == brre_pkg::REG_MIN_WIDTH) begin
      width_floor = val & 'h7FF;
    end else begin
      skip_limit = val & 'h3FF;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic put(input int value, input bit last);
    pixel_backlog.push_back(pixel_item_t'{brre_pkg::PIX_W'(value), last});
    items_queued++;
  endtask

  // A row of foreground runs separated by gaps around the bridging limit.
  task automatic gen_row(input int len);
    int col;
    int r;
    int g;
    col = 0;
    g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    for (int k = 0; k < g && col < len; k++) begin
      put(0, col == len - 1);
      col++;
    end
    while (col < len) begin
      r = $urandom_range(1, 6);
      for (int k = 0; k < r && col < len; k++) begin
        put($urandom_range(1, 255), col == len - 1);
        col++;
      end
      case ($urandom_range(0, 3))
        0: g = skip_limit;
        1: g = skip_limit + 1;
        2: g = $urandom_range(0, skip_limit + 2);
        default: g = $urandom_range(1, 3);
      endcase
      for (int k = 0; k < g && col < len; k++) begin
        put(0, col == len - 1);
        col++;
      end
    end
  endtask

  task automatic noise_row(input int len);
    for (int k = 0; k < len; k++) begin
      put(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255), k == len - 1);
    end
  endtask

  // Waits until every item has gone in and every result has come out.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (pixel_backlog.size() != 0 || pixel_valid || due_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of items with random gaps, holding each item until taken.
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        if (track_pixel(pixel, row_last, staged_result)) begin
          due_results.push_back(staged_result);
        end
      end
      if (!(pixel_valid && !pixel_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          pixel_valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          staged = pixel_backlog.pop_front();
          pixel <= staged.value;
          row_last <= staged.last;
          pixel_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on its own pattern.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left <= 0;
      stall_tick <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result seg %0d..%0d row_end %0b",
                                    seg_start, seg_end, row_end));
        end else begin
          expected_now = due_results.pop_front();
          if (has_segment !== expected_now.has_segment) begin
            report_mismatch($sformatf("has_segment got %0b want %0b",
                                      has_segment, expected_now.has_segment));
          end
          if (seg_start !== expected_now.seg_start) begin
            report_mismatch($sformatf("seg_start got %0d want %0d",
                                      seg_start, expected_now.seg_start));
          end
          if (seg_end !== expected_now.seg_end) begin
            report_mismatch($sformatf("seg_end got %0d want %0d",
                                      seg_end, expected_now.seg_end));
          end
          if (row_end !== expected_now.row_end) begin
            report_mismatch($sformatf("row_end got %0b want %0b",
                                      row_end, expected_now.row_end));
          end
        end
        result_index++;
      end
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
      end
      if (holds_seen != hold_requests) begin
        holds_seen <= hold_requests;
        hold_left <= HOLD_CYCLES;
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else begin
        case (stall_mode)
          2'd0: result_ready <= 1'b1;
          2'd1: result_ready <= 1'($urandom_range(0, 1));
          2'd2: result_ready <= ($urandom_range(0, 7) != 0);
          default: result_ready <= ((stall_tick % 5) < 3);
        endcase
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    int mw;
    int ms;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Single-pixel rows, an empty row and runs closed by a one-pixel gap.
    write_reg(brre_pkg::REG_MIN_WIDTH, 1);
    write_reg(brre_pkg::REG_MAX_SKIP, 0);
    put(8'hFF, 1'b1);
    put(8'h00, 1'b1);
    put(8'h01, 1'b0);
    put(8'h00, 1'b0);
    put(8'h80, 1'b0);
    put(8'h00, 1'b0);
    put(8'h7F, 1'b1);
    settle();

    // Bridged gaps with no width floor; the row ends inside an open gap.
    write_reg(brre_pkg::REG_MIN_WIDTH, 0);
    write_reg(brre_pkg::REG_MAX_SKIP, 2);
    put(8'h55, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'hAA, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h02, 1'b0);
    put(8'h00, 1'b1);
    settle();

    // Width floor: one run long enough, two too short.
    write_reg(brre_pkg::REG_MIN_WIDTH, 3);
    write_reg(brre_pkg::REG_MAX_SKIP, 1);
    put(8'h04, 1'b0);
    put(8'h08, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h10, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h20, 1'b1);
    settle();

    // Two longer structured rows with wide bridging.
    write_reg(brre_pkg::REG_MIN_WIDTH, $urandom_range(0, 64));
    write_reg(brre_pkg::REG_MAX_SKIP, $urandom_range(8, 40));
    gen_row($urandom_range(60, 90));
    gen_row($urandom_range(60, 90));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: mw = 0;
        1: mw = 1;
        2: mw = $urandom_range(2, 6);
        3: mw = $urandom_range(0, 16);
        4: mw = 1024;
        default: mw = $urandom_range(0, 1024);
      endcase
      case ($urandom_range(0, 5))
        0: ms = 0;
        1: ms = 1;
        2: ms = $urandom_range(2, 5);
        3: ms = $urandom_range(0, 12);
        4: ms = 1023;
        default: ms = $urandom_range(0, 1023);
      endcase
      write_reg(brre_pkg::REG_MAX_SKIP, ms);
      write_reg(brre_pkg::REG_MIN_WIDTH, mw);
      // In one phase the receiver stops for a long while so the block backs up.
      if (p == RANDOM_PHASES / 3) begin
        @(negedge clk);
        hold_requests++;
      end
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        if ($urandom_range(0, 6) == 0) begin
          noise_row($urandom_range(1, 40));
        end else begin
          gen_row($urandom_range(1, 48));
        end
      end
      settle();
    end

    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
